@@ design/ictr_pkg.sv @@
// ----------------------------------------------------------------------------
// ictr_pkg
// Shared types and constants of the inversion counter: tree size, counter
// and total widths, the stored counter word and the walk controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package ictr_pkg;

  localparam int VALUE_W    = 16;
  localparam int VALUE_BITS = 16;
  localparam int NODE_BITS  = VALUE_BITS + 1;
  localparam int NODE_COUNT = 1 << NODE_BITS;
  localparam int LEVEL_BITS = $clog2(VALUE_BITS);
  localparam int COUNT_BITS = 17;
  localparam int TOTAL_BITS = 32;
  localparam int EPOCH_BITS = 4;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
  localparam logic [LEVEL_BITS-1:0] LEVEL_LAST = LEVEL_BITS'(VALUE_BITS - 1);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [TOTAL_BITS-1:0] total_t;
  typedef logic [EPOCH_BITS-1:0] epoch_t;

  typedef struct packed {
    epoch_t epoch;
    count_t count;
  } word_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_TAIL  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } walk_status_t;

endpackage

`default_nettype wire

@@ design/inversion_counter_unit.sv @@
// ----------------------------------------------------------------------------
// inversion_counter_unit
// Inversion counter over values supplied last element first, using a binary
// prefix tree of saturating counters in one two-read-port memory.
//
//   channel | signals                         | transfer when
//   --------+---------------------------------+--------------------------
//   input   | value, is_final                 | in_valid && in_ready
//   output  | running_total, sequence_done    | out_valid && out_ready
//
// An item walks the tree one level per cycle through the counter memory,
// pipelined read then write, between a start step and a finish step.
// After reset, and after every 16th sequence when the epoch tag wraps, a
// clearing pass over all 2^(VALUE_BITS+1) memory words holds in_ready low.
// A result waits in the output register; the walk holds its result until
// that register is free, and accepts the next item once it has handed over.
// ----------------------------------------------------------------------------
`default_nettype none

module inversion_counter_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [ictr_pkg::VALUE_W-1:0]      value,
  input  wire logic                              is_final,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output ictr_pkg::total_t                       running_total,
  output logic                                   sequence_done
);

  ictr_pkg::walk_status_t              status;
  ictr_pkg::total_t                    total;
  logic                                final_out;
  logic                                start;
  logic                                take;
  logic                                rd_en;
  logic [ictr_pkg::VALUE_BITS-1:0]     rd_node;
  ictr_pkg::epoch_t                    epoch;
  ictr_pkg::count_t                    zero_cnt;
  ictr_pkg::count_t                    one_cnt;
  logic                                wr_en;
  logic [ictr_pkg::NODE_BITS-1:0]      wr_node;
  ictr_pkg::word_t                     wr_word;

  assign in_ready = status.idle;
  assign start    = in_valid && in_ready;
  assign take     = status.res_valid && (!out_valid || out_ready);

  ictr_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value_in  (value[ictr_pkg::VALUE_BITS-1:0]),
    .final_in  (is_final),
    .take      (take),
    .status    (status),
    .total     (total),
    .final_out (final_out),
    .rd_en     (rd_en),
    .rd_node   (rd_node),
    .epoch     (epoch),
    .zero_cnt  (zero_cnt),
    .one_cnt   (one_cnt),
    .wr_en     (wr_en),
    .wr_node   (wr_node),
    .wr_word   (wr_word)
  );

  ictr_store u_store (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_node  (rd_node),
    .epoch    (epoch),
    .zero_cnt (zero_cnt),
    .one_cnt  (one_cnt),
    .wr_en    (wr_en),
    .wr_node  (wr_node),
    .wr_word  (wr_word)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      running_total <= total;
      sequence_done <= final_out;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after a transfer");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    take |=> (out_valid && running_total == $past(total)))
    else $error("walk result not captured in output register");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !in_ready)
    else $error("input ready before clearing pass");

endmodule

`default_nettype wire

@@ design/ictr_store.sv @@
// ----------------------------------------------------------------------------
// ictr_store
// Prefix counter memory, indexed by heap node. One write port and two
// registered read ports that fetch both children of a node. A word whose
// epoch tag differs from the current epoch reads as a zero count.
// ----------------------------------------------------------------------------
`default_nettype none

module ictr_store (
  input  wire logic                                  clk,
  input  wire logic                                  rd_en,
  input  wire logic [ictr_pkg::VALUE_BITS-1:0]       rd_node,
  input  wire ictr_pkg::epoch_t                      epoch,
  output ictr_pkg::count_t                           zero_cnt,
  output ictr_pkg::count_t                           one_cnt,
  input  wire logic                                  wr_en,
  input  wire logic [ictr_pkg::NODE_BITS-1:0]        wr_node,
  input  wire ictr_pkg::word_t                       wr_word
);

  ictr_pkg::word_t mem [ictr_pkg::NODE_COUNT];
  ictr_pkg::word_t word_zero;
  ictr_pkg::word_t word_one;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_node] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      word_zero <= mem[{rd_node, 1'b0}];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      word_one <= mem[{rd_node, 1'b1}];
    end
  end

  assign zero_cnt = (word_zero.epoch == epoch) ? word_zero.count : '0;
  assign one_cnt  = (word_one.epoch == epoch) ? word_one.count : '0;

endmodule

`default_nettype wire

@@ design/ictr_walk.sv @@
// ----------------------------------------------------------------------------
// ictr_walk
// Bit-serial tree walk: shifts the value out one bit per cycle, builds the
// heap node on the fly, accumulates the saturating total and bumps the
// counter on the path. Also runs the clearing pass and the epoch count.
// ----------------------------------------------------------------------------
`default_nettype none

module ictr_walk (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic [ictr_pkg::VALUE_BITS-1:0]       value_in,
  input  wire logic                                  final_in,
  input  wire logic                                  take,
  output ictr_pkg::walk_status_t                     status,
  output ictr_pkg::total_t                           total,
  output logic                                       final_out,
  output logic                                       rd_en,
  output logic [ictr_pkg::VALUE_BITS-1:0]            rd_node,
  output ictr_pkg::epoch_t                           epoch,
  input  wire ictr_pkg::count_t                      zero_cnt,
  input  wire ictr_pkg::count_t                      one_cnt,
  output logic                                       wr_en,
  output logic [ictr_pkg::NODE_BITS-1:0]             wr_node,
  output ictr_pkg::word_t                            wr_word
);

  ictr_pkg::state_t                    state;
  logic [ictr_pkg::VALUE_BITS-1:0]     vshift;
  logic [ictr_pkg::VALUE_BITS-1:0]     h;
  logic [ictr_pkg::LEVEL_BITS-1:0]     lvl;
  logic                                p_valid;
  logic                                p_bit;
  logic [ictr_pkg::VALUE_BITS-1:0]     p_h;
  logic [ictr_pkg::NODE_BITS-1:0]      clr_addr;
  ictr_pkg::count_t                    path_cnt;
  ictr_pkg::count_t                    bump_cnt;
  logic [ictr_pkg::TOTAL_BITS:0]       sum;
  ictr_pkg::total_t                    total_next;

  // write stage of the walk
  always_comb begin
    path_cnt = p_bit ? one_cnt : zero_cnt;
    bump_cnt = (path_cnt == ictr_pkg::COUNT_MAX) ? path_cnt : path_cnt + 1'b1;
    sum = {1'b0, total} + {{(ictr_pkg::TOTAL_BITS + 1 - ictr_pkg::COUNT_BITS){1'b0}}, zero_cnt};
    if (!p_bit) begin
      total_next = total;
    end else if (sum[ictr_pkg::TOTAL_BITS]) begin
      total_next = ictr_pkg::TOTAL_MAX;
    end else begin
      total_next = sum[ictr_pkg::TOTAL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ictr_pkg::ST_CLEAR;
      clr_addr <= '0;
      epoch    <= '0;
      p_valid  <= 1'b0;
      total    <= '0;
    end else begin
      p_valid <= (state == ictr_pkg::ST_WALK);
      p_bit   <= vshift[ictr_pkg::VALUE_BITS-1];
      p_h     <= h;
      if (p_valid) begin
        total <= total_next;
      end
      unique case (state)
        ictr_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= ictr_pkg::ST_IDLE;
          end
        end
        ictr_pkg::ST_IDLE: begin
          if (start) begin
            vshift    <= value_in;
            h         <= ictr_pkg::VALUE_BITS'(1);
            lvl       <= '0;
            final_out <= final_in;
            state     <= ictr_pkg::ST_WALK;
          end
        end
        ictr_pkg::ST_WALK: begin
          vshift <= {vshift[ictr_pkg::VALUE_BITS-2:0], 1'b0};
          h      <= {h[ictr_pkg::VALUE_BITS-2:0], vshift[ictr_pkg::VALUE_BITS-1]};
          lvl    <= lvl + 1'b1;
          if (lvl == ictr_pkg::LEVEL_LAST) begin
            state <= ictr_pkg::ST_TAIL;
          end
        end
        ictr_pkg::ST_TAIL: begin
          state <= ictr_pkg::ST_DONE;
        end
        ictr_pkg::ST_DONE: begin
          if (take) begin
            if (final_out) begin
              total <= '0;
              if (epoch == '1) begin
                epoch    <= '0;
                clr_addr <= '0;
                state    <= ictr_pkg::ST_CLEAR;
              end else begin
                epoch <= epoch + 1'b1;
                state <= ictr_pkg::ST_IDLE;
              end
            end else begin
              state <= ictr_pkg::ST_IDLE;
            end
          end
        end
        default: begin
          state <= ictr_pkg::ST_CLEAR;
          clr_addr <= '0;
        end
      endcase
    end
  end

  assign rd_en   = (state == ictr_pkg::ST_WALK);
  assign rd_node = h;

  always_comb begin
    if (state == ictr_pkg::ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_node = clr_addr;
      wr_word = '0;
    end else begin
      wr_en         = p_valid;
      wr_node       = {p_h, p_bit};
      wr_word.epoch = epoch;
      wr_word.count = bump_cnt;
    end
  end

  assign status.idle      = (state == ictr_pkg::ST_IDLE);
  assign status.res_valid = (state == ictr_pkg::ST_DONE);

endmodule

`default_nettype wire
